// File: rtl/joystick_to_attitude_quaternion_macros.svh
// assertion macros shared by the attitude pipeline
// depends on nothing; included by the top level
`ifndef JOYSTICK_TO_ATTITUDE_QUATERNION_MACROS_SVH
`define JOYSTICK_TO_ATTITUDE_QUATERNION_MACROS_SVH
`define JAQ_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define JAQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/jaq_pkg.sv
// constants and fixed-point helpers for the attitude pipeline
// depends on nothing
package jaq_pkg;
    localparam int AxisWidthDefault = 16;
    localparam int CordicSteps = 16;
    localparam logic signed [31:0] CordicX0 = 32'sd652032874;
    localparam logic [17:0] HalfPiQ16 = 18'd102944;
    localparam logic [17:0] PiQ16 = 18'd205887;
    localparam logic [15:0] ThrustReset = 16'd32768;
    localparam logic [14:0] RollReset = 15'd6434;
    localparam logic [14:0] PitchReset = 15'd6434;
    localparam logic [14:0] YawReset = 15'd25736;

    typedef enum logic [1:0] {
        REG_THRUST = 2'd0,
        REG_ROLL = 2'd1,
        REG_PITCH = 2'd2,
        REG_YAW = 2'd3
    } reg_idx_t;

    function automatic logic signed [18:0] atan_q16(input int i);
        logic signed [18:0] r;
        r = '0;
        unique case (i)
            0: r = 19'sd51472;
            1: r = 19'sd30385;
            2: r = 19'sd16055;
            3: r = 19'sd8150;
            4: r = 19'sd4091;
            5: r = 19'sd2047;
            6: r = 19'sd1024;
            7: r = 19'sd512;
            8: r = 19'sd256;
            9: r = 19'sd128;
            10: r = 19'sd64;
            11: r = 19'sd32;
            12: r = 19'sd16;
            13: r = 19'sd8;
            14: r = 19'sd4;
            15: r = 19'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // q.60 product rounded half up to q.30
    function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd536870912) >>> 30;
        return t[31:0];
    endfunction
endpackage

// File: rtl/joystick_to_attitude_quaternion.sv
// Throughput: one beat per cycle while the output is not stalled; the pipeline is
// two scaling stages, 16 cordic stages, a sign stage, two product levels and a sum
// stage, all holding on a stall.
// Reset: asynchronous, clears valid bits and loads the limit registers
// with thrust 1.0, roll and pitch pi/4, yaw pi.
// file holds the top level; depends on jaq_pkg and the macros header
`include "joystick_to_attitude_quaternion_macros.svh"
module joystick_to_attitude_quaternion
    import jaq_pkg::*;
#(
    parameter int AXIS_WIDTH = AxisWidthDefault
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [AXIS_WIDTH-1:0] roll_axis,
    input  logic signed [AXIS_WIDTH-1:0] pitch_axis,
    input  logic signed [AXIS_WIDTH-1:0] yaw_axis,
    input  logic signed [AXIS_WIDTH-1:0] thrust_axis,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [15:0]           quat_w,
    output logic signed [15:0]           quat_x,
    output logic signed [15:0]           quat_y,
    output logic signed [15:0]           quat_z,
    output logic [15:0]                  thrust_out,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_data
);
    localparam int NC = CordicSteps;
    localparam int DEPTH = NC + 6;
    localparam int MW = AXIS_WIDTH + 15;

    logic [15:0] thrust_limit_reg;
    logic [14:0] roll_limit_reg, pitch_limit_reg, yaw_limit_reg;

    logic [DEPTH-1:0] vld_reg;
    logic adv;

    assign adv = !(out_stall && vld_reg[DEPTH-1]);
    assign in_stall = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thrust_limit_reg <= ThrustReset;
            roll_limit_reg <= RollReset;
            pitch_limit_reg <= PitchReset;
            yaw_limit_reg <= YawReset;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_THRUST: thrust_limit_reg <= cfg_data;
                REG_ROLL: roll_limit_reg <= cfg_data[14:0];
                REG_PITCH: pitch_limit_reg <= cfg_data[14:0];
                REG_YAW: yaw_limit_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // stage 0: magnitudes, signs and limits registered
    logic [AXIS_WIDTH-1:0] mag_reg [3];
    logic [2:0] neg0_reg;
    logic [14:0] lim0_reg [3];
    logic [15:0] thr_lim_reg;
    logic signed [AXIS_WIDTH-1:0] thr_ax_reg;
    logic signed [AXIS_WIDTH-1:0] ax_in [3];

    assign ax_in[0] = roll_axis;
    assign ax_in[1] = pitch_axis;
    assign ax_in[2] = yaw_axis;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg0_reg[k] <= ax_in[k][AXIS_WIDTH-1];
                mag_reg[k] <= ax_in[k][AXIS_WIDTH-1] ? (~ax_in[k] + 1'b1) : ax_in[k];
            end
            lim0_reg[0] <= roll_limit_reg;
            lim0_reg[1] <= pitch_limit_reg;
            lim0_reg[2] <= yaw_limit_reg;
            thr_ax_reg <= thrust_axis;
            thr_lim_reg <= thrust_limit_reg;
        end
    end

    // cordic stage registers, entry 0 is loaded by stage 1
    logic signed [31:0] cx_reg [NC+1][3];
    logic signed [31:0] cy_reg [NC+1][3];
    logic signed [18:0] cz_reg [NC+1][3];
    logic [2:0] cf_reg [NC+1];
    logic [2:0] cn_reg [NC+1];
    logic [15:0] ct_reg [NC+1];

    // stage 1: product and rounding to q.16 half angle, fold
    logic [MW-1:0] prod1 [3];
    logic [MW-1:0] ang1 [3];
    logic [AXIS_WIDTH+15:0] tp1;
    logic [AXIS_WIDTH+15:0] tr1;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod1[k] = MW'(mag_reg[k]) * MW'(lim0_reg[k]);
            ang1[k] = (prod1[k] + (MW'(1) << (AXIS_WIDTH-4))) >> (AXIS_WIDTH-3);
        end
        tp1 = (AXIS_WIDTH+16)'(unsigned'(thr_ax_reg)) * (AXIS_WIDTH+16)'(thr_lim_reg);
        tr1 = (tp1 + ((AXIS_WIDTH+16)'(1) << (AXIS_WIDTH-2))) >> (AXIS_WIDTH-1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cx_reg[0][k] <= CordicX0;
                cy_reg[0][k] <= '0;
                cn_reg[0][k] <= neg0_reg[k];
                cf_reg[0][k] <= ang1[k] > MW'(HalfPiQ16);
                cz_reg[0][k] <= (ang1[k] > MW'(HalfPiQ16))
                    ? 19'(signed'({1'b0, PiQ16}) - signed'({1'b0, ang1[k][17:0]}))
                    : 19'(ang1[k]);
            end
            if (thr_ax_reg[AXIS_WIDTH-1] || thr_ax_reg == '0)
                ct_reg[0] <= '0;
            else if (tr1 > (AXIS_WIDTH+16)'(32768))
                ct_reg[0] <= 16'd32768;
            else
                ct_reg[0] <= tr1[15:0];
        end
    end

    // cordic stages
    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (!cz_reg[i][k][18])
                    begin
                        cx_reg[i+1][k] <= cx_reg[i][k] - (cy_reg[i][k] >>> i);
                        cy_reg[i+1][k] <= cy_reg[i][k] + (cx_reg[i][k] >>> i);
                        cz_reg[i+1][k] <= cz_reg[i][k] - atan_q16(i);
                    end
                    else
                    begin
                        cx_reg[i+1][k] <= cx_reg[i][k] + (cy_reg[i][k] >>> i);
                        cy_reg[i+1][k] <= cy_reg[i][k] - (cx_reg[i][k] >>> i);
                        cz_reg[i+1][k] <= cz_reg[i][k] + atan_q16(i);
                    end
                end
                cf_reg[i+1] <= cf_reg[i];
                cn_reg[i+1] <= cn_reg[i];
                ct_reg[i+1] <= ct_reg[i];
            end
        end
    end

    // sign fixups
    logic signed [31:0] s_reg [3], c_reg [3];
    logic [15:0] t2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c_reg[k] <= cf_reg[NC][k] ? -cx_reg[NC][k] : cx_reg[NC][k];
                s_reg[k] <= cn_reg[NC][k] ? -cy_reg[NC][k] : cy_reg[NC][k];
            end
            t2_reg <= ct_reg[NC];
        end
    end

    // pair products: cr*cp, sr*sp, sr*cp, cr*sp
    logic signed [31:0] pr_reg [4];
    logic signed [31:0] sy3_reg, cy3_reg;
    logic [15:0] t3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg[0] <= rnd30(64'(c_reg[0]) * 64'(c_reg[1]));
            pr_reg[1] <= rnd30(64'(s_reg[0]) * 64'(s_reg[1]));
            pr_reg[2] <= rnd30(64'(s_reg[0]) * 64'(c_reg[1]));
            pr_reg[3] <= rnd30(64'(c_reg[0]) * 64'(s_reg[1]));
            sy3_reg <= s_reg[2];
            cy3_reg <= c_reg[2];
            t3_reg <= t2_reg;
        end
    end

    // triple products
    logic signed [31:0] tq_reg [8];
    logic [15:0] t4_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tq_reg[0] <= rnd30(64'(pr_reg[0]) * 64'(cy3_reg));
            tq_reg[1] <= rnd30(64'(pr_reg[1]) * 64'(sy3_reg));
            tq_reg[2] <= rnd30(64'(pr_reg[2]) * 64'(cy3_reg));
            tq_reg[3] <= rnd30(64'(pr_reg[3]) * 64'(sy3_reg));
            tq_reg[4] <= rnd30(64'(pr_reg[3]) * 64'(cy3_reg));
            tq_reg[5] <= rnd30(64'(pr_reg[2]) * 64'(sy3_reg));
            tq_reg[6] <= rnd30(64'(pr_reg[0]) * 64'(sy3_reg));
            tq_reg[7] <= rnd30(64'(pr_reg[1]) * 64'(cy3_reg));
            t4_reg <= t3_reg;
        end
    end

    // sums, rounding, saturation
    logic signed [33:0] sum5 [4];
    logic signed [33:0] q5 [4];
    logic signed [15:0] qo_reg [4];
    logic [15:0] t5_reg;
    always_comb
    begin
        sum5[0] = 34'(tq_reg[0]) + 34'(tq_reg[1]);
        sum5[1] = 34'(tq_reg[2]) - 34'(tq_reg[3]);
        sum5[2] = 34'(tq_reg[4]) + 34'(tq_reg[5]);
        sum5[3] = 34'(tq_reg[6]) - 34'(tq_reg[7]);
        for (int k = 0; k < 4; k++)
            q5[k] = (sum5[k] + 34'sd16384) >>> 15;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (q5[k] > 34'sd32767)
                    qo_reg[k] <= 16'sd32767;
                else if (q5[k] < -34'sd32768)
                    qo_reg[k] <= -16'sd32768;
                else
                    qo_reg[k] <= q5[k][15:0];
            end
            t5_reg <= t4_reg;
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign quat_w = qo_reg[0];
    assign quat_x = qo_reg[1];
    assign quat_y = qo_reg[2];
    assign quat_z = qo_reg[3];
    assign thrust_out = t5_reg;

    `JAQ_ASSERT_IMPL(a_thr_max, clk, rst_n, out_valid, thrust_out <= 16'd32768)
    `JAQ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `JAQ_ASSERT_NEXT(a_hold_w, clk, rst_n, out_valid && out_stall, $stable(quat_w))
    `JAQ_ASSERT_IMPL(a_stall, clk, rst_n, in_stall, out_valid && out_stall)
endmodule

// File: bench/joystick_to_attitude_quaternion_tb.sv
// testbench for the joystick to attitude quaternion pipeline
// checks every output beat against an in-bench fixed-point cordic predictor
// depends on jaq_pkg and the rtl top level only
`timescale 1ns / 1ps

module joystick_to_attitude_quaternion_tb;
    import jaq_pkg::*;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [15:0]        thrust;
    } attitude_t;

    localparam longint ATAN_TAB [16] = '{
        51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] roll_axis;
    logic signed [15:0] pitch_axis;
    logic signed [15:0] yaw_axis;
    logic signed [15:0] thrust_axis;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [15:0]        thrust_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    logic [15:0] lim_thrust;
    logic [14:0] lim_roll;
    logic [14:0] lim_pitch;
    logic [14:0] lim_yaw;

    attitude_t pending_attitudes[$];
    int        error_count;
    int        hold_left;
    int        stall_run;
    bit        steady_flow;

    joystick_to_attitude_quaternion DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .roll_axis(roll_axis),
        .pitch_axis(pitch_axis),
        .yaw_axis(yaw_axis),
        .thrust_axis(thrust_axis),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .quat_w(quat_w),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z),
        .thrust_out(thrust_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // half angle sine and cosine in q.30
    function automatic void half_sincos(input longint axis, input longint limit,
                                        output longint s, output longint c);
        bit     neg;
        bit     fold;
        longint m;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        neg = axis < 0;
        m = (((neg ? -axis : axis) * limit) + 4096) >>> 13;
        fold = m > 102944;
        if (fold)
            m = 205887 - m;
        x = 652032874;
        y = 0;
        z = m;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ATAN_TAB[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ATAN_TAB[i];
            end
        end
        c = fold ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint triple(input longint a, input longint b, input longint c);
        return round_shift(round_shift(a * b, 30) * c, 30);
    endfunction

    function automatic logic [15:0] sat_q15(input longint v);
        longint q;
        q = round_shift(v, 15);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic attitude_t predict_attitude(input logic signed [15:0] r,
                                                   input logic signed [15:0] p,
                                                   input logic signed [15:0] yw,
                                                   input logic signed [15:0] t);
        attitude_t a;
        longint    sr, cr, sp, cp, sy, cy;
        longint    thr;
        half_sincos(longint'(r), longint'(lim_roll), sr, cr);
        half_sincos(longint'(p), longint'(lim_pitch), sp, cp);
        half_sincos(longint'(yw), longint'(lim_yaw), sy, cy);
        a.w = sat_q15(triple(cr, cp, cy) + triple(sr, sp, sy));
        a.x = sat_q15(triple(sr, cp, cy) - triple(cr, sp, sy));
        a.y = sat_q15(triple(cr, sp, cy) + triple(sr, cp, sy));
        a.z = sat_q15(triple(cr, cp, sy) - triple(sr, sp, cy));
        thr = 0;
        if (t > 0)
        begin
            thr = (longint'(t) * longint'(lim_thrust) + 16384) >>> 15;
            if (thr > 32768)
                thr = 32768;
        end
        a.thrust = thr[15:0];
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_axes(input logic [15:0] r, input logic [15:0] p,
                             input logic [15:0] yw, input logic [15:0] t,
                             input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        roll_axis = r;
        pitch_axis = p;
        yaw_axis = yw;
        thrust_axis = t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_attitudes.push_back(predict_attitude(r, p, yw, t));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_attitudes.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_limit(input reg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_THRUST: lim_thrust = value;
            REG_ROLL:   lim_roll = value[14:0];
            REG_PITCH:  lim_pitch = value[14:0];
            REG_YAW:    lim_yaw = value[14:0];
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_limits(input logic [15:0] t, input logic [15:0] r,
                              input logic [15:0] p, input logic [15:0] yw);
        wait_drained();
        write_limit(REG_THRUST, t);
        write_limit(REG_ROLL, r);
        write_limit(REG_PITCH, p);
        write_limit(REG_YAW, yw);
    endtask

    task automatic send_random_axes(input bit no_gap);
        logic [15:0] v [4];
        for (int k = 0; k < 4; k++)
        begin
            case ($urandom_range(0, 9))
                0: v[k] = 16'h8000;
                1: v[k] = 16'h7fff;
                2: v[k] = 16'h0000;
                3: v[k] = 16'($urandom_range(0, 15));
                default: v[k] = 16'($urandom());
            endcase
        end
        send_axes(v[0], v[1], v[2], v[3], no_gap);
    endtask

    task automatic test_directed();
        logic [15:0] corner [5];
        corner = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff};
        for (int k = 0; k < 5; k++)
            send_axes(corner[k], corner[k], corner[k], corner[k], 1'b0);
        send_axes(16'h7fff, 16'h0000, 16'h0000, 16'h4000, 1'b0);
        send_axes(16'h0000, 16'h8000, 16'h0000, 16'hc000, 1'b0);
        send_axes(16'h0000, 16'h0000, 16'h7fff, 16'h2000, 1'b0);
        send_axes(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0);
        send_axes(16'h5555, 16'haaaa, 16'h3333, 16'hcccc, 1'b0);
        // widest angles, past the cordic fold, and thrust clamp
        set_limits(16'hffff, 16'h7fff, 16'h7fff, 16'h7fff);
        for (int k = 0; k < 5; k++)
            send_axes(corner[k], corner[k], corner[k], corner[k], 1'b0);
        send_axes(16'h6000, 16'ha000, 16'h7000, 16'h7fff, 1'b0);
        // zero limits
        set_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_axes(16'h7fff, 16'h8000, 16'h1234, 16'h7fff, 1'b0);
        send_axes(16'h8000, 16'h7fff, 16'h8000, 16'h0001, 1'b0);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 49) == 0)
                steady_flow = ~steady_flow;
            send_random_axes(1'b0);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_left = 200;
        for (int n = 0; n < 60; n++)
            send_random_axes(1'b1);
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 10; n++)
            send_random_axes(1'b0);
        wait_drained();
        for (int n = 0; n < 10; n++)
            send_random_axes(1'b0);
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (stall_run > 0)
        begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end
        else if (!steady_flow && $urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        attitude_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_attitudes.size() == 0)
            begin
                $display("unexpected output beat at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_attitudes.pop_front();
                if (quat_w !== want.w)
                    report_mismatch("quat_w", quat_w, want.w);
                if (quat_x !== want.x)
                    report_mismatch("quat_x", quat_x, want.x);
                if (quat_y !== want.y)
                    report_mismatch("quat_y", quat_y, want.y);
                if (quat_z !== want.z)
                    report_mismatch("quat_z", quat_z, want.z);
                if (thrust_out !== want.thrust)
                    report_mismatch("thrust_out", thrust_out, want.thrust);
            end
        end
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        roll_axis = '0;
        pitch_axis = '0;
        yaw_axis = '0;
        thrust_axis = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_THRUST;
        cfg_data = '0;
        error_count = 0;
        hold_left = 0;
        stall_run = 0;
        steady_flow = 1'b0;
        lim_thrust = ThrustReset;
        lim_roll = RollReset;
        lim_pitch = PitchReset;
        lim_yaw = YawReset;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        set_limits(ThrustReset, RollReset, PitchReset, YawReset);
        test_random(120);
        test_backpressure();
        set_limits(16'($urandom()), 16'($urandom_range(0, 25736)),
                   16'($urandom_range(0, 25736)), 16'($urandom_range(0, 25736)));
        test_random(120);
        test_drain_pause();
        set_limits(16'($urandom()), 16'($urandom_range(0, 32767)),
                   16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)));
        test_random(120);
        set_limits(16'd32768, 16'd25736, 16'd25736, 16'd25736);
        test_random(60);

        wait_drained();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/jaq_pkg.sv
rtl/joystick_to_attitude_quaternion.sv
bench/joystick_to_attitude_quaternion_tb.sv
